/* design/assert_macros.svh */
// Assertion macros used by the port-level checker of the shape function evaluator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is high.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Clocked assertion that is also checked during reset.
`define ASSERT_CLK_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* design/fsfe_pkg.sv */
// Package with the types, constants and helper functions of the shape function evaluator.
package fsfe_pkg;

  // Fixed-point format of coordinates and results.
  localparam int FRAC_BITS = 16;
  localparam int COORD_W   = 17;

  // Internal operand, product and accumulation widths.
  localparam int OP_W   = 23;
  localparam int PROD_W = 2 * OP_W;
  localparam int ACC_W  = OP_W + 3;

  // Result fields.
  localparam int NODE_W    = 3;
  localparam int SHAPE_W   = 19;
  localparam int DERIV_W   = 21;
  localparam int SHAPE_LIM = 131072;
  localparam int DERIV_LIM = 524288;

  // Stream bus widths.
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 64;

  localparam logic signed [OP_W-1:0]   ONE  = OP_W'(1 << FRAC_BITS);
  localparam logic signed [PROD_W-1:0] HALF = PROD_W'(1 << (FRAC_BITS - 1));
  // Three in operand format, used by two corner nodes of the eight-node quad.
  localparam logic signed [OP_W-1:0]   THREE = OP_W'(3 << FRAC_BITS);

  typedef enum logic [1:0] {
    KIND_TRI3  = 2'd0,
    KIND_QUAD4 = 2'd1,
    KIND_TRI6  = 2'd2,
    KIND_QUAD8 = 2'd3
  } kind_t;

  // Per-node control that travels down the pipeline with the operands.
  typedef struct packed {
    logic [1:0]              n_shift;
    logic signed [OP_W-1:0]  n_sub;
    logic                    d_x4;
    logic                    d_neg;
    logic                    e_x4;
    logic                    e_neg;
    logic [NODE_W-1:0]       node;
    logic                    last;
  } ctrl_t;

  // Multiplier operands for one node: shape (two chained products) and both derivatives.
  typedef struct packed {
    logic signed [OP_W-1:0] na;
    logic signed [OP_W-1:0] nb;
    logic signed [OP_W-1:0] nc;
    logic signed [OP_W-1:0] da;
    logic signed [OP_W-1:0] db;
    logic signed [OP_W-1:0] ea;
    logic signed [OP_W-1:0] eb;
    ctrl_t                  ctrl;
  } ops_t;

  // Number of nodes of each element kind.
  function automatic logic [NODE_W:0] node_count(input kind_t kind);
    logic [NODE_W:0] cnt;
    case (kind)
      KIND_TRI3:  cnt = (NODE_W+1)'(3);
      KIND_QUAD4: cnt = (NODE_W+1)'(4);
      KIND_TRI6:  cnt = (NODE_W+1)'(6);
      default:    cnt = (NODE_W+1)'(8);
    endcase
    return cnt;
  endfunction

  // Clamp a value to the symmetric range [-lim, lim].
  function automatic logic signed [ACC_W-1:0] sat(input logic signed [ACC_W-1:0] v,
                                                  input int lim);
    logic signed [ACC_W-1:0] r;
    if (v > lim) begin
      r = ACC_W'(lim);
    end else if (v < -lim) begin
      r = ACC_W'(-lim);
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

/* design/fsfe_mulq.sv */
// Two-stage fixed-point multiplier with round-to-nearest rescaling.
module fsfe_mulq (
  input  logic                              clk,
  input  logic                              en,
  input  logic signed [fsfe_pkg::OP_W-1:0]  a,
  input  logic signed [fsfe_pkg::OP_W-1:0]  b,
  output logic signed [fsfe_pkg::OP_W-1:0]  p
);

  logic signed [fsfe_pkg::PROD_W-1:0] prod;
  logic signed [fsfe_pkg::PROD_W-1:0] prod_rnd;

  // Add half an LSB of the result so that the floor shift rounds halves upwards.
  assign prod_rnd = prod + fsfe_pkg::HALF;

  // First stage holds the full product, second stage the rescaled value.
  always_ff @(posedge clk) begin
    if (en) begin
      prod <= a * b;
      p    <= fsfe_pkg::OP_W'(prod_rnd >>> fsfe_pkg::FRAC_BITS);
    end
  end

endmodule

/* design/fsfe_operand_sel.sv */
// Operand and control selection for one node of the configured element.
module fsfe_operand_sel (
  input  logic [fsfe_pkg::COORD_W-1:0] x,
  input  logic [fsfe_pkg::COORD_W-1:0] y,
  input  fsfe_pkg::kind_t              kind,
  input  logic [fsfe_pkg::NODE_W-1:0]  node,
  input  logic                         last,
  output fsfe_pkg::ops_t               ops
);

  logic signed [fsfe_pkg::OP_W-1:0] xs, ys, xm, ym, z;
  logic signed [fsfe_pkg::OP_W-1:0] x2, y2, x4, y4;

  // Derived coordinates: complements, the triangle's third coordinate and scaled terms.
  always_comb begin
    xs = signed'(fsfe_pkg::OP_W'(x));
    ys = signed'(fsfe_pkg::OP_W'(y));
    xm = fsfe_pkg::ONE - xs;
    ym = fsfe_pkg::ONE - ys;
    z  = fsfe_pkg::ONE - xs - ys;
    x2 = xs <<< 1;
    y2 = ys <<< 1;
    x4 = xs <<< 2;
    y4 = ys <<< 2;
  end

  // Each quantity is expressed as a rounded product; a plain value is multiplied by one,
  // which passes it through exactly.
  always_comb begin
    ops              = '0;
    ops.nb           = fsfe_pkg::ONE;
    ops.nc           = fsfe_pkg::ONE;
    ops.db           = fsfe_pkg::ONE;
    ops.eb           = fsfe_pkg::ONE;
    ops.ctrl.node    = node;
    ops.ctrl.last    = last;
    case (kind)
      fsfe_pkg::KIND_TRI3: begin
        case (node)
          3'd0: begin
            ops.na = z;
            ops.da = -fsfe_pkg::ONE;
            ops.ea = -fsfe_pkg::ONE;
          end
          3'd1: begin
            ops.na = xs;
            ops.da = fsfe_pkg::ONE;
          end
          default: begin
            ops.na = ys;
            ops.ea = fsfe_pkg::ONE;
          end
        endcase
      end
      fsfe_pkg::KIND_QUAD4: begin
        case (node)
          3'd0: begin
            ops.na = xm; ops.nb = ym;
            ops.da = -ym;
            ops.ea = -xm;
          end
          3'd1: begin
            ops.na = xs; ops.nb = ym;
            ops.da = ym;
            ops.ea = -xs;
          end
          3'd2: begin
            ops.na = xs; ops.nb = ys;
            ops.da = ys;
            ops.ea = xs;
          end
          default: begin
            ops.na = xm; ops.nb = ys;
            ops.da = -ys;
            ops.ea = xm;
          end
        endcase
      end
      fsfe_pkg::KIND_TRI6: begin
        case (node)
          3'd0: begin
            ops.na = z; ops.nb = z;
            ops.ctrl.n_shift = 2'd1; ops.ctrl.n_sub = z;
            ops.da = fsfe_pkg::ONE - (z <<< 2);
            ops.ea = fsfe_pkg::ONE - (z <<< 2);
          end
          3'd1: begin
            ops.na = xs; ops.nb = xs;
            ops.ctrl.n_shift = 2'd1; ops.ctrl.n_sub = xs;
            ops.da = x4 - fsfe_pkg::ONE;
          end
          3'd2: begin
            ops.na = ys; ops.nb = ys;
            ops.ctrl.n_shift = 2'd1; ops.ctrl.n_sub = ys;
            ops.ea = y4 - fsfe_pkg::ONE;
          end
          3'd3: begin
            ops.na = z; ops.nb = xs;
            ops.ctrl.n_shift = 2'd2;
            ops.da = (z - xs) <<< 2;
            ops.ea = -x4;
          end
          3'd4: begin
            ops.na = xs; ops.nb = ys;
            ops.ctrl.n_shift = 2'd2;
            ops.da = y4;
            ops.ea = x4;
          end
          default: begin
            ops.na = ys; ops.nb = z;
            ops.ctrl.n_shift = 2'd2;
            ops.da = -y4;
            ops.ea = (z - ys) <<< 2;
          end
        endcase
      end
      default: begin
        case (node)
          3'd0: begin
            ops.na = xm; ops.nb = ym; ops.nc = fsfe_pkg::ONE - x2 - y2;
            ops.da = ym; ops.db = x4 + y2 - fsfe_pkg::THREE;
            ops.ea = xm; ops.eb = y4 + x2 - fsfe_pkg::THREE;
          end
          3'd1: begin
            ops.na = xs; ops.nb = ym; ops.nc = x2 - y2 - fsfe_pkg::ONE;
            ops.da = ym; ops.db = x4 - y2 - fsfe_pkg::ONE;
            ops.ea = xs; ops.eb = y4 - x2 - fsfe_pkg::ONE;
          end
          3'd2: begin
            ops.na = xs; ops.nb = ys; ops.nc = x2 + y2 - fsfe_pkg::THREE;
            ops.da = ys; ops.db = x4 + y2 - fsfe_pkg::THREE;
            ops.ea = xs; ops.eb = y4 + x2 - fsfe_pkg::THREE;
          end
          3'd3: begin
            ops.na = xm; ops.nb = ys; ops.nc = y2 - x2 - fsfe_pkg::ONE;
            ops.da = ys; ops.db = x4 - y2 - fsfe_pkg::ONE;
            ops.ea = xm; ops.eb = y4 - x2 - fsfe_pkg::ONE;
          end
          3'd4: begin
            ops.na = xm; ops.nb = ym; ops.nc = xs;
            ops.ctrl.n_shift = 2'd2;
            ops.da = ym; ops.db = fsfe_pkg::ONE - x2; ops.ctrl.d_x4 = 1'b1;
            ops.ea = xs; ops.eb = xm; ops.ctrl.e_x4 = 1'b1; ops.ctrl.e_neg = 1'b1;
          end
          3'd5: begin
            ops.na = xs; ops.nb = ym; ops.nc = ys;
            ops.ctrl.n_shift = 2'd2;
            ops.da = ym; ops.db = ys; ops.ctrl.d_x4 = 1'b1;
            ops.ea = xs; ops.eb = fsfe_pkg::ONE - y2; ops.ctrl.e_x4 = 1'b1;
          end
          3'd6: begin
            ops.na = xs; ops.nb = ys; ops.nc = xm;
            ops.ctrl.n_shift = 2'd2;
            ops.da = ys; ops.db = fsfe_pkg::ONE - x2; ops.ctrl.d_x4 = 1'b1;
            ops.ea = xs; ops.eb = xm; ops.ctrl.e_x4 = 1'b1;
          end
          default: begin
            ops.na = xm; ops.nb = ys; ops.nc = ym;
            ops.ctrl.n_shift = 2'd2;
            ops.da = ys; ops.db = ym; ops.ctrl.d_x4 = 1'b1; ops.ctrl.d_neg = 1'b1;
            ops.ea = xm; ops.eb = fsfe_pkg::ONE - y2; ops.ctrl.e_x4 = 1'b1;
          end
        endcase
      end
    endcase
  end

endmodule

/* design/fem_shape_function_evaluator.sv */
// Throughput: one node result per cycle unless the receiver stalls, so a point gives 3, 4,
// 6 or 8 results for the three-node triangle, bilinear quad, six-node triangle and
// eight-node quad; the node sequencer issuing one node per cycle into the shared
// multiplier pipeline sets this. Reset (synchronous, rst high) empties the pipeline and
// selects the three-node triangle.
module fem_shape_function_evaluator (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_wr_en,
  input  logic [1:0]                           cfg_wr_data,   // element_kind
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  logic [fsfe_pkg::IN_TDATA_W-1:0]      s_axis_tdata,  // xi[16:0], eta[33:17]
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  output logic [fsfe_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,  // shape_value[18:0],
                                                               // deriv_xi[39:19],
                                                               // deriv_eta[60:40]
  output logic [fsfe_pkg::NODE_W-1:0]          m_axis_tuser,  // node_index[2:0]
  output logic                                 m_axis_tlast   // last_node
);

  fsfe_pkg::kind_t                    element_kind;

  // Node sequencer.
  logic                               seq_busy;
  logic [fsfe_pkg::COORD_W-1:0]       seq_x;
  logic [fsfe_pkg::COORD_W-1:0]       seq_y;
  fsfe_pkg::kind_t                    seq_kind;
  logic [fsfe_pkg::NODE_W-1:0]        seq_node;
  logic                               seq_last;

  // Pipeline stages.
  logic                               adv;
  fsfe_pkg::ops_t                     ops_sel;
  fsfe_pkg::ops_t                     ops1;
  logic                               v1, v2, v3, v4, v5;
  fsfe_pkg::ctrl_t                    ctrl2, ctrl3, ctrl4, ctrl5;
  logic signed [fsfe_pkg::OP_W-1:0]   nc2, nc3;
  logic signed [fsfe_pkg::OP_W-1:0]   n1_p, n2_p, d_p, e_p;
  logic signed [fsfe_pkg::ACC_W-1:0]  d_scaled, e_scaled;
  logic signed [fsfe_pkg::ACC_W-1:0]  dval4, eval4, dval5, eval5;
  logic signed [fsfe_pkg::ACC_W-1:0]  n_acc, n_sat, d_sat, e_sat;

  // Output register.
  logic                               out_valid;
  logic signed [fsfe_pkg::SHAPE_W-1:0] out_shape;
  logic signed [fsfe_pkg::DERIV_W-1:0] out_dx;
  logic signed [fsfe_pkg::DERIV_W-1:0] out_dy;
  logic [fsfe_pkg::NODE_W-1:0]        out_node;
  logic                               out_last;

  // The whole pipeline moves together whenever the output register can take a beat.
  assign adv           = !out_valid || m_axis_tready;
  assign seq_last      = seq_node == fsfe_pkg::NODE_W'(fsfe_pkg::node_count(seq_kind) - 1);
  assign s_axis_tready = adv && (!seq_busy || seq_last);

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      element_kind <= fsfe_pkg::KIND_TRI3;
    end else if (cfg_wr_en) begin
      element_kind <= fsfe_pkg::kind_t'(cfg_wr_data);
    end
  end

  // The sequencer holds a point and steps through its nodes, taking the next point on the
  // cycle of the last node.
  always_ff @(posedge clk) begin
    if (rst) begin
      seq_busy <= 1'b0;
      seq_node <= '0;
    end else if (adv) begin
      if (!seq_busy || seq_last) begin
        seq_busy <= s_axis_tvalid;
        seq_node <= '0;
        if (s_axis_tvalid) begin
          seq_x    <= s_axis_tdata[fsfe_pkg::COORD_W-1:0];
          seq_y    <= s_axis_tdata[2*fsfe_pkg::COORD_W-1:fsfe_pkg::COORD_W];
          seq_kind <= element_kind;
        end
      end else begin
        seq_node <= seq_node + 1'b1;
      end
    end
  end

  fsfe_operand_sel u_operand_sel (
    .x    (seq_x),
    .y    (seq_y),
    .kind (seq_kind),
    .node (seq_node),
    .last (seq_last),
    .ops  (ops_sel)
  );

  // Valid bits travel alongside the data.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else if (adv) begin
      v1 <= seq_busy;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
    end
  end

  // Stage one registers the operands; control, the third shape factor and derivatives follow.
  always_ff @(posedge clk) begin
    if (adv) begin
      ops1  <= ops_sel;
      ctrl2 <= ops1.ctrl;
      nc2   <= ops1.nc;
      ctrl3 <= ctrl2;
      nc3   <= nc2;
      ctrl4 <= ctrl3;
      dval4 <= d_scaled;
      eval4 <= e_scaled;
      ctrl5 <= ctrl4;
      dval5 <= dval4;
      eval5 <= eval4;
    end
  end

  // First products: shape partial product and both derivatives.
  fsfe_mulq u_mul_n1 (.clk(clk), .en(adv), .a(ops1.na), .b(ops1.nb), .p(n1_p));
  fsfe_mulq u_mul_d  (.clk(clk), .en(adv), .a(ops1.da), .b(ops1.db), .p(d_p));
  fsfe_mulq u_mul_e  (.clk(clk), .en(adv), .a(ops1.ea), .b(ops1.eb), .p(e_p));

  // Second shape product, fed by the rounded first one.
  fsfe_mulq u_mul_n2 (.clk(clk), .en(adv), .a(n1_p), .b(nc3), .p(n2_p));

  // Derivative scaling by four and sign, after rounding.
  always_comb begin
    d_scaled = ctrl3.d_x4 ? (fsfe_pkg::ACC_W'(d_p) <<< 2) : fsfe_pkg::ACC_W'(d_p);
    e_scaled = ctrl3.e_x4 ? (fsfe_pkg::ACC_W'(e_p) <<< 2) : fsfe_pkg::ACC_W'(e_p);
    if (ctrl3.d_neg) begin
      d_scaled = -d_scaled;
    end
    if (ctrl3.e_neg) begin
      e_scaled = -e_scaled;
    end
  end

  // Final shape value and saturation of all three results.
  always_comb begin
    n_acc = (fsfe_pkg::ACC_W'(n2_p) <<< ctrl5.n_shift) - fsfe_pkg::ACC_W'(ctrl5.n_sub);
    n_sat = fsfe_pkg::sat(n_acc, fsfe_pkg::SHAPE_LIM);
    d_sat = fsfe_pkg::sat(dval5, fsfe_pkg::DERIV_LIM);
    e_sat = fsfe_pkg::sat(eval5, fsfe_pkg::DERIV_LIM);
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_shape <= fsfe_pkg::SHAPE_W'(n_sat);
      out_dx    <= fsfe_pkg::DERIV_W'(d_sat);
      out_dy    <= fsfe_pkg::DERIV_W'(e_sat);
      out_node  <= ctrl5.node;
      out_last  <= ctrl5.last;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {
    (fsfe_pkg::OUT_TDATA_W - fsfe_pkg::SHAPE_W - 2 * fsfe_pkg::DERIV_W)'(0),
    out_dy, out_dx, out_shape
  };
  assign m_axis_tuser  = out_node;
  assign m_axis_tlast  = out_last;

endmodule

/* design/fsfe_checker.sv */
// Port-level checks of the shape function evaluator and their binding to the top level.
`include "assert_macros.svh"

module fsfe_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              m_axis_tvalid,
  input logic                              m_axis_tready,
  input logic [fsfe_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
  input logic [fsfe_pkg::NODE_W-1:0]       m_axis_tuser,
  input logic                              m_axis_tlast
);

  // No result beat is offered straight after reset.
  `ASSERT_CLK_ALWAYS(a_no_valid_after_reset, $past(rst) |-> !m_axis_tvalid, "beat after reset")

  // A stalled result beat stays offered and unchanged.
  `ASSERT_CLK(a_hold_on_stall, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "stalled beat changed")

  // The last node of a point is the final node of one of the four element kinds.
  `ASSERT_CLK(a_last_node_index, m_axis_tvalid && m_axis_tlast |-> m_axis_tuser == 3'd2 || m_axis_tuser == 3'd3 || m_axis_tuser == 3'd5 || m_axis_tuser == 3'd7, "bad last node")

  // Shape values stay inside the saturation limits.
  `ASSERT_CLK(a_shape_range, m_axis_tvalid |-> $signed(m_axis_tdata[18:0]) >= -131072 && $signed(m_axis_tdata[18:0]) <= 131072, "shape out of range")

  // Derivatives with respect to xi stay inside the saturation limits.
  `ASSERT_CLK(a_deriv_xi_range, m_axis_tvalid |-> $signed(m_axis_tdata[39:19]) >= -524288 && $signed(m_axis_tdata[39:19]) <= 524288, "deriv_xi out of range")

endmodule

bind fem_shape_function_evaluator fsfe_checker u_fsfe_checker (.*);

/* tb/sv/shape_result_checker.sv */
// Checker that predicts and compares the node results of the shape function evaluator.
module shape_result_checker
  import fsfe_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_wr_en,
  input  logic [1:0]             cfg_wr_data,
  input  logic                   s_axis_tvalid,
  input  logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // xi[16:0], eta[33:17]
  input  logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  input  logic [OUT_TDATA_W-1:0] m_axis_tdata,   // shape_value[18:0], deriv_xi[39:19],
                                                 // deriv_eta[60:40]
  input  logic [NODE_W-1:0]      m_axis_tuser,   // node_index[2:0]
  input  logic                   m_axis_tlast,   // last_node
  output int                     mismatches,
  output int                     pending,
  output int                     points_seen,
  output int                     nodes_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  // One node result as it leaves the block.
  typedef struct packed {
    logic [NODE_W-1:0]         node;
    logic signed [SHAPE_W-1:0] shape;
    logic signed [DERIV_W-1:0] d_xi;
    logic signed [DERIV_W-1:0] d_eta;
    logic                      last_node;
  } node_res_t;

  node_res_t expected_nodes[$];
  kind_t     kind_shadow;

  // Fixed-point product, rounded to nearest with halves toward plus infinity.
  function automatic longint qmul(input longint a, input longint b);
    return (a * b + (longint'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
  endfunction

  function automatic longint clip(input longint v, input longint lim);
    longint r;
    r = v;
    if (v > lim) r = lim;
    if (v < -lim) r = -lim;
    return r;
  endfunction

  // Shape values and derivatives of every node of one element at (x, y).
  function automatic int eval_shape_nodes(input kind_t kind, input longint x, input longint y,
                                          output node_res_t res[8]);
    longint one, xm, ym, z;
    longint n[8], dx[8], dy[8];
    int cnt;
    one = longint'(1) <<< FRAC_BITS;
    xm = one - x;
    ym = one - y;
    z = one - x - y;
    for (int k = 0; k < 8; k++) begin
      n[k] = 0;
      dx[k] = 0;
      dy[k] = 0;
    end
    case (kind)
      KIND_TRI3: begin
        cnt = 3;
        n[0] = z;
        n[1] = x;
        n[2] = y;
        dx[0] = -one;
        dy[0] = -one;
        dx[1] = one;
        dy[2] = one;
      end
      KIND_QUAD4: begin
        cnt = 4;
        n[0] = qmul(xm, ym);
        n[1] = qmul(x, ym);
        n[2] = qmul(x, y);
        n[3] = qmul(xm, y);
        dx[0] = -ym; dy[0] = -xm;
        dx[1] = ym;  dy[1] = -x;
        dx[2] = y;   dy[2] = x;
        dx[3] = -y;  dy[3] = xm;
      end
      KIND_TRI6: begin
        cnt = 6;
        n[0] = 2 * qmul(z, z) - z;
        n[1] = 2 * qmul(x, x) - x;
        n[2] = 2 * qmul(y, y) - y;
        n[3] = 4 * qmul(z, x);
        n[4] = 4 * qmul(x, y);
        n[5] = 4 * qmul(y, z);
        dx[0] = one - 4 * z;  dy[0] = one - 4 * z;
        dx[1] = 4 * x - one;
        dy[2] = 4 * y - one;
        dx[3] = 4 * (z - x);  dy[3] = -4 * x;
        dx[4] = 4 * y;        dy[4] = 4 * x;
        dx[5] = -4 * y;       dy[5] = 4 * (z - y);
      end
      default: begin
        cnt = 8;
        n[0] = qmul(qmul(xm, ym), one - 2 * x - 2 * y);
        n[1] = qmul(qmul(x, ym), -one + 2 * x - 2 * y);
        n[2] = qmul(qmul(x, y), -3 * one + 2 * x + 2 * y);
        n[3] = qmul(qmul(xm, y), -one - 2 * x + 2 * y);
        n[4] = 4 * qmul(qmul(xm, ym), x);
        n[5] = 4 * qmul(qmul(x, ym), y);
        n[6] = 4 * qmul(qmul(x, y), xm);
        n[7] = 4 * qmul(qmul(xm, y), ym);
        dx[0] = qmul(ym, -3 * one + 4 * x + 2 * y);
        dy[0] = qmul(xm, -3 * one + 4 * y + 2 * x);
        dx[1] = qmul(ym, -one + 4 * x - 2 * y);
        dy[1] = qmul(x, -one - 2 * x + 4 * y);
        dx[2] = qmul(y, -3 * one + 4 * x + 2 * y);
        dy[2] = qmul(x, -3 * one + 4 * y + 2 * x);
        dx[3] = qmul(y, -one + 4 * x - 2 * y);
        dy[3] = qmul(xm, -one - 2 * x + 4 * y);
        dx[4] = 4 * qmul(ym, one - 2 * x);
        dy[4] = -4 * qmul(x, xm);
        dx[5] = 4 * qmul(ym, y);
        dy[5] = 4 * qmul(x, one - 2 * y);
        dx[6] = 4 * qmul(y, one - 2 * x);
        dy[6] = 4 * qmul(x, xm);
        dx[7] = -4 * qmul(y, ym);
        dy[7] = 4 * qmul(xm, one - 2 * y);
      end
    endcase
    // Saturate and cut each value down to its field width.
    for (int k = 0; k < 8; k++) begin
      res[k].node = NODE_W'(k);
      res[k].shape = SHAPE_W'(clip(n[k], SHAPE_LIM));
      res[k].d_xi = DERIV_W'(clip(dx[k], DERIV_LIM));
      res[k].d_eta = DERIV_W'(clip(dy[k], DERIV_LIM));
      res[k].last_node = (k == cnt - 1);
    end
    return cnt;
  endfunction

  initial begin
    mismatches = 0;
    pending = 0;
    points_seen = 0;
    nodes_checked = 0;
    kind_shadow = KIND_TRI3;
  end

  // Compare output beats, predict input beats, then follow register writes.
  always @(posedge clk) begin : watch
    node_res_t want, got;
    node_res_t run[8];
    int cnt;
    if (rst) begin
      expected_nodes.delete();
      kind_shadow = KIND_TRI3;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.node = m_axis_tuser;
        got.shape = m_axis_tdata[SHAPE_W-1:0];
        got.d_xi = m_axis_tdata[SHAPE_W +: DERIV_W];
        got.d_eta = m_axis_tdata[SHAPE_W + DERIV_W +: DERIV_W];
        got.last_node = m_axis_tlast;
        nodes_checked++;
        if (expected_nodes.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%t: node result with none expected: node %0d shape %0d dxi %0d deta %0d last %0b",
                     $realtime, got.node, got.shape, got.d_xi, got.d_eta, got.last_node);
        end else begin
          want = expected_nodes.pop_front();
          if (got.node !== want.node || got.shape !== want.shape || got.d_xi !== want.d_xi ||
              got.d_eta !== want.d_eta || got.last_node !== want.last_node) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("%t: node result mismatch, kind %0d", $realtime, kind_shadow);
              $display("  expected node %0d shape %0d dxi %0d deta %0d last %0b",
                       want.node, want.shape, want.d_xi, want.d_eta, want.last_node);
              $display("  actual   node %0d shape %0d dxi %0d deta %0d last %0b",
                       got.node, got.shape, got.d_xi, got.d_eta, got.last_node);
            end
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        cnt = eval_shape_nodes(kind_shadow, longint'(s_axis_tdata[COORD_W-1:0]),
                               longint'(s_axis_tdata[COORD_W +: COORD_W]), run);
        for (int k = 0; k < cnt; k++) expected_nodes.push_back(run[k]);
        points_seen++;
      end
      if (cfg_wr_en) kind_shadow = kind_t'(cfg_wr_data);
    end
    pending = expected_nodes.size();
  end

endmodule

/* tb/sv/tb_fem_shape_function_evaluator.sv */
// Top of the shape function evaluator testbench: clock, reset, stimulus and verdict.
module tb_fem_shape_function_evaluator;
  timeunit 1ns;
  timeprecision 1ps;
  import fsfe_pkg::*;

  localparam int UNIT = 1 << FRAC_BITS;
  localparam int COORD_MAX = (1 << COORD_W) - 1;
  localparam int HOLD_CYCLES = 120;
  localparam int PHASES = 6;
  localparam int PHASE_POINTS = 18;

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   cfg_wr_en;
  logic [1:0]             cfg_wr_data;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic [NODE_W-1:0]      m_axis_tuser;
  logic                   m_axis_tlast;

  int   mismatches, pending, points_seen, nodes_checked;
  int   kinds_set;
  logic hold_req = 1'b0;

  fem_shape_function_evaluator uut (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  shape_result_checker checker_i (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .mismatches    (mismatches),
    .pending       (pending),
    .points_seen   (points_seen),
    .nodes_checked (nodes_checked)
  );

  // 8 ns clock.
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Gap before a point: mostly none or short, now and then long.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Coordinate: mostly inside [0, 1], with corners and the full field range mixed in.
  function automatic logic [COORD_W-1:0] pick_coord();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll == 0) return '0;
    if (roll == 1) return COORD_W'(UNIT);
    if (roll <= 3) return COORD_W'($urandom_range(0, COORD_MAX));
    return COORD_W'($urandom_range(0, UNIT));
  endfunction

  // Offer one point after a gap and hold it until the block takes the beat.
  task automatic send_point(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                            input int gap);
    repeat (gap) begin
      @(negedge clk);
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    @(negedge clk);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= IN_TDATA_W'({y, x});
    do @(posedge clk); while (!(s_axis_tvalid && s_axis_tready));
  endtask

  // Change the element kind once the block has drained.
  task automatic set_kind(input kind_t kind);
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= kind;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    kinds_set++;
  endtask

  // Receiver: random stalls, calm stretches, and one long hold-off on request.
  initial begin : receiver
    int stall_left, calm_left, roll;
    m_axis_tready = 1'b0;
    stall_left = 0;
    calm_left = 0;
    forever begin
      @(negedge clk);
      if (rst) begin
        m_axis_tready <= 1'b0;
      end else if (hold_req) begin
        hold_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else if (stall_left > 0) begin
        m_axis_tready <= 1'b0;
        stall_left--;
      end else if (calm_left > 0) begin
        m_axis_tready <= 1'b1;
        calm_left--;
      end else begin
        roll = $urandom_range(0, 99);
        if (roll < 70) begin
          m_axis_tready <= 1'b1;
        end else if (roll < 88) begin
          m_axis_tready <= 1'b0;
          stall_left = $urandom_range(0, 2);
        end else if (roll < 95) begin
          m_axis_tready <= 1'b0;
          stall_left = $urandom_range(8, 30);
        end else begin
          m_axis_tready <= 1'b1;
          calm_left = $urandom_range(20, 60);
        end
      end
    end
  end

  // Stimulus and verdict.
  initial begin : stimulus
    logic [COORD_W-1:0] corner_x[6], corner_y[6];
    kind_t kind;
    rst = 1'b1;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    kinds_set = 0;
    // Origin, unit corners, the all-ones point far outside, and an interior point.
    corner_x = '{COORD_W'(0), COORD_W'(UNIT), COORD_W'(0), COORD_W'(UNIT),
                 COORD_W'(COORD_MAX), COORD_W'(UNIT / 2)};
    corner_y = '{COORD_W'(0), COORD_W'(0), COORD_W'(UNIT), COORD_W'(UNIT),
                 COORD_W'(COORD_MAX), COORD_W'(UNIT / 3)};
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed corners for every element kind.
    for (int k = 0; k < 4; k++) begin
      set_kind(kind_t'(k));
      for (int p = 0; p < 6; p++) send_point(corner_x[p], corner_y[p], pick_gap());
    end

    // Random phases: the first fills the block against a held receiver, the second
    // runs the sender without gaps, the rest pick their kind at random.
    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph == 0) kind = KIND_QUAD8;
      else if (ph == 1) kind = KIND_TRI3;
      else kind = kind_t'($urandom_range(0, 3));
      set_kind(kind);
      if (ph == 0) hold_req = 1'b1;
      for (int i = 0; i < PHASE_POINTS; i++)
        send_point(pick_coord(), pick_coord(), (ph <= 1) ? 0 : pick_gap());
    end

    // Drain, then allow for anything still in the pipeline.
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);

    $display("Ran %0d points through %0d kind settings, all four element kinds, corners and",
             points_seen, kinds_set);
    $display("out-of-element points included; %0d node results checked, %0d mismatches.",
             nodes_checked, mismatches);
    if (mismatches == 0) begin
      $display("PASS fem_shape_function_evaluator");
    end else begin
      $display("FAIL fem_shape_function_evaluator");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #3ms;
    $display("FAIL fem_shape_function_evaluator");
    $finish;
  end

endmodule
